### rtl/wildcard_to_regex_translator_unit_defines.svh
// ----------------------------------------------------------------------------
// wildcard_to_regex_translator_unit_defines
// assertion macros used by the translator sequencer rtl
// ----------------------------------------------------------------------------
`ifndef WILDCARD_TO_REGEX_TRANSLATOR_UNIT_DEFINES_SVH
`define WILDCARD_TO_REGEX_TRANSLATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define WTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WTR_ASSERT(lbl, prop, msg)
`define WTR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/wtr_pkg.sv
// ----------------------------------------------------------------------------
// wtr_pkg
// shared types and character codes of the wildcard to regex translator
// ----------------------------------------------------------------------------
package wtr_pkg;

  localparam int BRACKET_DEPTH_DEF = 15;

  typedef logic [15:0] unit_t;

  typedef struct packed {
    unit_t unit;
    logic  run_last;
    logic  pattern_done;
    logic  overflow;
  } emit_t;

  localparam unit_t CH_BANG   = 16'h0021;
  localparam unit_t CH_DOLLAR = 16'h0024;
  localparam unit_t CH_LPAR   = 16'h0028;
  localparam unit_t CH_RPAR   = 16'h0029;
  localparam unit_t CH_STAR   = 16'h002A;
  localparam unit_t CH_PLUS   = 16'h002B;
  localparam unit_t CH_DOT    = 16'h002E;
  localparam unit_t CH_ZERO   = 16'h0030;
  localparam unit_t CH_QMARK  = 16'h003F;
  localparam unit_t CH_LBRK   = 16'h005B;
  localparam unit_t CH_BSL    = 16'h005C;
  localparam unit_t CH_RBRK   = 16'h005D;
  localparam unit_t CH_CARET  = 16'h005E;
  localparam unit_t CH_LBRACE = 16'h007B;
  localparam unit_t CH_BAR    = 16'h007C;
  localparam unit_t CH_RBRACE = 16'h007D;
  localparam unit_t CH_NUL    = 16'h0000;

  function automatic logic is_word(unit_t u);
    return ((u >= 16'h0041) && (u <= 16'h005A)) ||
           ((u >= 16'h0061) && (u <= 16'h007A)) ||
           ((u >= 16'h0030) && (u <= 16'h0039)) ||
           (u == 16'h005F);
  endfunction

endpackage

### rtl/wtr_bkt_mem.sv
// ----------------------------------------------------------------------------
// wtr_bkt_mem
// bracket class store, one write port and one registered read port
// ----------------------------------------------------------------------------
module wtr_bkt_mem #(
  parameter int  BRACKET_DEPTH = wtr_pkg::BRACKET_DEPTH_DEF,
  localparam int IW = (BRACKET_DEPTH > 1) ? $clog2(BRACKET_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  wtr_pkg::unit_t  wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output wtr_pkg::unit_t  rdata
);
  import wtr_pkg::*;

  unit_t mem_q [BRACKET_DEPTH];
  unit_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/wtr_seq.sv
// ----------------------------------------------------------------------------
// wtr_seq
// decodes one pattern unit, writes the bracket store and sequences the
// result words, walking the store on a class release or an end-of-pattern flush
// ----------------------------------------------------------------------------
`include "wildcard_to_regex_translator_unit_defines.svh"

module wtr_seq #(
  parameter int  BRACKET_DEPTH = wtr_pkg::BRACKET_DEPTH_DEF,
  localparam int IW = (BRACKET_DEPTH > 1) ? $clog2(BRACKET_DEPTH) : 1,
  localparam int FW = $clog2(BRACKET_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wtr_pkg::unit_t  in_code_unit,
  input  logic            in_end_of_pattern,
  input  logic            out_free,
  output logic            emit_valid,
  output wtr_pkg::emit_t  emit,
  output logic            mem_we,
  output logic [IW-1:0]   mem_waddr,
  output wtr_pkg::unit_t  mem_wdata,
  output logic            mem_re,
  output logic [IW-1:0]   mem_raddr,
  input  wtr_pkg::unit_t  mem_rdata
);
  import wtr_pkg::*;

  localparam logic [FW-1:0] DEPTH_F = FW'(BRACKET_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PUSH = 6'b000010,
    S_FIX  = 6'b000100,
    S_RD   = 6'b001000,
    S_EMIT = 6'b010000,
    S_TAIL = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic          esc_r, esc_nxt;
  logic          inb_r, inb_nxt;
  logic          jo_r, jo_nxt;
  logic          ovf_r, ovf_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] k_r, k_nxt;
  logic          half_r, half_nxt;
  logic          last_r, last_nxt;
  unit_t         fix_r [4];
  unit_t         fix_nxt [4];
  logic [2:0]    fix_n_r, fix_n_nxt;
  logic [1:0]    fix_i_r, fix_i_nxt;
  logic [1:0]    push_n_r, push_n_nxt;
  unit_t         push_val_r, push_val_nxt;
  logic          walk_r, walk_nxt;
  logic          flush_r, flush_nxt;
  logic          tail_r, tail_nxt;
  logic          close_r, close_nxt;

  // decode of the offered word
  unit_t      d_fix [4];
  logic [2:0] d_fix_n;
  logic [1:0] d_push_n;
  unit_t      d_push_val;
  logic       d_release;
  logic       d_open;
  logic       d_esc;
  unit_t      c;

  assign c = in_code_unit;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_fix[i] = CH_BSL;
    end
    d_fix_n    = 3'd0;
    d_push_n   = 2'd0;
    d_push_val = c;
    d_release  = 1'b0;
    d_open     = 1'b0;
    d_esc      = esc_r;
    if (inb_r) begin
      if (jo_r && (c == CH_BANG)) begin
        d_push_n   = 2'd1;
        d_push_val = CH_CARET;
      end else if (c == CH_RBRK) begin
        d_release = 1'b1;
      end else begin
        d_push_n = (c == CH_BSL) ? 2'd2 : 2'd1;
      end
    end else begin
      d_esc = 1'b0;
      unique case (c)
        CH_BSL: begin
          d_esc   = 1'b1;
          d_fix_n = {esc_r & in_end_of_pattern, esc_r ^ in_end_of_pattern, 1'b0};
        end
        CH_STAR: begin
          d_fix[0] = esc_r ? CH_BSL : CH_DOT;
          d_fix[1] = CH_STAR;
          d_fix_n  = 3'd2;
        end
        CH_QMARK: begin
          if (esc_r) begin
            d_fix[1] = CH_QMARK;
            d_fix_n  = 3'd2;
          end else begin
            d_fix[0] = CH_DOT;
            d_fix_n  = 3'd1;
          end
        end
        CH_DOLLAR, CH_LPAR, CH_RPAR, CH_PLUS, CH_DOT,
        CH_CARET, CH_LBRACE, CH_BAR, CH_RBRACE: begin
          if (esc_r) begin
            d_fix[3] = c;
            d_fix_n  = 3'd4;
          end else begin
            d_fix[1] = c;
            d_fix_n  = 3'd2;
          end
        end
        CH_LBRK: begin
          if (esc_r) begin
            d_fix[1] = CH_LBRK;
            d_fix_n  = 3'd2;
          end else begin
            d_open     = 1'b1;
            d_push_n   = 2'd1;
            d_push_val = CH_LBRK;
          end
        end
        CH_RBRK: begin
          if (esc_r) begin
            d_fix[1] = CH_RBRK;
            d_fix_n  = 3'd2;
          end else begin
            d_fix[0] = CH_RBRK;
            d_fix_n  = 3'd1;
          end
        end
        default: begin
          if (esc_r) begin
            d_fix[2] = c;
            d_fix_n  = 3'd3;
          end else begin
            d_fix[0] = c;
            d_fix_n  = 3'd1;
          end
        end
      endcase
    end
    if (in_end_of_pattern) begin
      d_esc = 1'b0;
    end
  end

  // sequencer
  logic  go_walk;
  logic  finish;
  logic  adv;
  logic  need_pre;
  logic  fix_end;
  logic  walk_end;
  unit_t walk_val;

  assign need_pre = flush_r && !is_word(mem_rdata) && !half_r;
  assign walk_val = (flush_r && (mem_rdata == CH_NUL)) ? CH_ZERO : mem_rdata;
  assign fix_end  = (({1'b0, fix_i_r} + 3'd1) == fix_n_r);
  assign walk_end = ((k_r + FW'(1)) == fill_r);

  always_comb begin
    state_nxt    = state_r;
    esc_nxt      = esc_r;
    inb_nxt      = inb_r;
    jo_nxt       = jo_r;
    ovf_nxt      = ovf_r;
    fill_nxt     = fill_r;
    k_nxt        = k_r;
    half_nxt     = half_r;
    last_nxt     = last_r;
    fix_nxt      = fix_r;
    fix_n_nxt    = fix_n_r;
    fix_i_nxt    = fix_i_r;
    push_n_nxt   = push_n_r;
    push_val_nxt = push_val_r;
    walk_nxt     = walk_r;
    flush_nxt    = flush_r;
    tail_nxt     = tail_r;
    close_nxt    = close_r;
    in_stall     = 1'b1;
    emit_valid   = 1'b0;
    emit         = '0;
    mem_we       = 1'b0;
    mem_waddr    = fill_r[IW-1:0];
    mem_wdata    = push_val_r;
    mem_re       = 1'b0;
    mem_raddr    = k_r[IW-1:0];
    go_walk      = 1'b0;
    finish       = 1'b0;
    adv          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          last_nxt     = in_end_of_pattern;
          fix_nxt      = d_fix;
          fix_n_nxt    = d_fix_n;
          fix_i_nxt    = 2'd0;
          push_n_nxt   = d_push_n;
          push_val_nxt = d_push_val;
          tail_nxt     = d_release;
          flush_nxt    = in_end_of_pattern & ((inb_r & ~d_release) | d_open);
          walk_nxt     = d_release | (in_end_of_pattern & ((inb_r & ~d_release) | d_open));
          close_nxt    = d_release | in_end_of_pattern;
          esc_nxt      = d_esc;
          inb_nxt      = ~in_end_of_pattern & ((inb_r & ~d_release) | d_open);
          jo_nxt       = ~in_end_of_pattern & d_open;
          if (d_open) begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_n_r != 2'd0) begin
          push_n_nxt = push_n_r - 2'd1;
          if (fill_r < DEPTH_F) begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (fix_n_r != 3'd0) begin
          state_nxt = S_FIX;
        end else begin
          go_walk = 1'b1;
        end
      end
      S_FIX: begin
        if (out_free) begin
          emit_valid         = 1'b1;
          emit.unit          = fix_r[fix_i_r];
          emit.run_last      = fix_end & ~walk_r;
          emit.pattern_done  = fix_end & ~walk_r & last_r;
          emit.overflow      = walk_r & ovf_r;
          fix_i_nxt          = fix_i_r + 2'd1;
          go_walk            = fix_end;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        half_nxt  = 1'b0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit_valid    = 1'b1;
          emit.overflow = ovf_r;
          if (need_pre) begin
            emit.unit = CH_BSL;
            half_nxt  = 1'b1;
          end else begin
            adv               = 1'b1;
            emit.unit         = walk_val;
            emit.run_last     = walk_end & ~tail_r;
            emit.pattern_done = walk_end & ~tail_r & last_r;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          emit_valid        = 1'b1;
          emit.unit         = CH_RBRK;
          emit.run_last     = 1'b1;
          emit.pattern_done = last_r;
          emit.overflow     = ovf_r;
          finish            = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      k_nxt = k_r + FW'(1);
      if (!walk_end) begin
        state_nxt = S_RD;
      end else if (tail_r) begin
        state_nxt = S_TAIL;
      end else begin
        finish = 1'b1;
      end
    end

    if (go_walk) begin
      if (walk_r && (fill_r != '0)) begin
        k_nxt     = '0;
        state_nxt = S_RD;
      end else if (tail_r) begin
        state_nxt = S_TAIL;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      state_nxt = S_IDLE;
      if (close_r) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      esc_r    <= 1'b0;
      inb_r    <= 1'b0;
      jo_r     <= 1'b0;
      ovf_r    <= 1'b0;
      fill_r   <= '0;
      push_n_r <= 2'd0;
      fix_n_r  <= 3'd0;
      fix_i_r  <= 2'd0;
      walk_r   <= 1'b0;
      flush_r  <= 1'b0;
      tail_r   <= 1'b0;
      close_r  <= 1'b0;
      last_r   <= 1'b0;
      k_r      <= '0;
      half_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      esc_r    <= esc_nxt;
      inb_r    <= inb_nxt;
      jo_r     <= jo_nxt;
      ovf_r    <= ovf_nxt;
      fill_r   <= fill_nxt;
      push_n_r <= push_n_nxt;
      fix_n_r  <= fix_n_nxt;
      fix_i_r  <= fix_i_nxt;
      walk_r   <= walk_nxt;
      flush_r  <= flush_nxt;
      tail_r   <= tail_nxt;
      close_r  <= close_nxt;
      last_r   <= last_nxt;
      k_r      <= k_nxt;
      half_r   <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fix_r      <= fix_nxt;
    push_val_r <= push_val_nxt;
  end

  `WTR_ASSERT(a_fill_max, fill_r <= DEPTH_F, "bracket fill beyond depth")
  `WTR_ASSERT(a_we_room, mem_we |-> (fill_r < DEPTH_F), "store write without room")
  `WTR_ASSERT_NEXT(a_we_fill, mem_we, fill_r == ($past(fill_r) + FW'(1)), "fill not bumped")
  `WTR_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE, "idle after accept")
  `WTR_ASSERT(a_emit_free, emit_valid |-> out_free, "word emitted into a full output")
  `WTR_ASSERT(a_idle_closed, (state_r == S_IDLE && !inb_r) |-> (fill_r == '0 && !ovf_r),
              "bracket state left open")

endmodule

### rtl/wildcard_to_regex_translator_unit.sv
// ----------------------------------------------------------------------------
// wildcard_to_regex_translator_unit
// Takes a wildcard pattern one code unit per input word and returns the
// regular expression text one code unit per output word. Items are handled
// one at a time: an item is accepted, then makes its bracket store writes
// (a backslash inside a class writes twice), is dispatched and emits its
// result words. A class release or an end-of-pattern flush walks the bracket
// store through its single read port, reading each stored unit and then
// emitting it, with a backslash before a unit that is escaped on flush, and
// a release ends with the closing bracket. Output stalls hold the sequencer.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module wildcard_to_regex_translator_unit #(
  parameter int BRACKET_DEPTH = wtr_pkg::BRACKET_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wtr_pkg::unit_t  in_code_unit,
  input  logic            in_end_of_pattern,
  output logic            out_valid,
  input  logic            out_stall,
  output wtr_pkg::unit_t  out_unit,
  output logic            out_run_last,
  output logic            out_pattern_done,
  output logic            out_overflow
);
  import wtr_pkg::*;

  localparam int IW = (BRACKET_DEPTH > 1) ? $clog2(BRACKET_DEPTH) : 1;

  logic          out_free;
  logic          emit_valid;
  emit_t         emit;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  unit_t         mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  unit_t         mem_rdata;

  logic          out_valid_r;
  emit_t         out_word_r;

  wtr_seq #(
    .BRACKET_DEPTH (BRACKET_DEPTH)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_unit      (in_code_unit),
    .in_end_of_pattern (in_end_of_pattern),
    .out_free          (out_free),
    .emit_valid        (emit_valid),
    .emit              (emit),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  wtr_bkt_mem #(
    .BRACKET_DEPTH (BRACKET_DEPTH)
  ) u_bkt_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output word register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      out_word_r <= emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_unit         = out_word_r.unit;
  assign out_run_last     = out_word_r.run_last;
  assign out_pattern_done = out_word_r.pattern_done;
  assign out_overflow     = out_word_r.overflow;

endmodule

### dv/wildcard_to_regex_translator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_to_regex_translator_unit_tb
// Self-checking bench for the wildcard to regex translator. Patterns are fed
// one code unit per word. Every accepted word is run through a behavioral
// translator in the bench, and its expected output words are queued. Each
// output word is checked field by field against the oldest queued word.
// Directed patterns cover escapes, metacharacters, bracket release and flush,
// and bracket overflow. These are followed by a long receiver hold-off and by
// random patterns under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module wildcard_to_regex_translator_unit_tb;
  import wtr_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int BRK_DEPTH     = BRACKET_DEPTH_DEF;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  unit_t in_code_unit;
  logic  in_end_of_pattern;
  logic  out_valid;
  logic  out_stall;
  unit_t out_unit;
  logic  out_run_last;
  logic  out_pattern_done;
  logic  out_overflow;

  wildcard_to_regex_translator_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_unit      (in_code_unit),
    .in_end_of_pattern (in_end_of_pattern),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_unit          (out_unit),
    .out_run_last      (out_run_last),
    .out_pattern_done  (out_pattern_done),
    .out_overflow      (out_overflow)
  );

  // translator state mirrored in the bench
  logic        esc_pend;
  logic        brk_open;
  logic        brk_fresh;
  logic        brk_dropped;
  unit_t       brk_buf [32];
  int unsigned brk_fill;

  emit_t       regex_q [$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  bit          offering;

  always #5 clk = ~clk;

  function automatic bit is_word_unit(unit_t u);
    if (u >= 16'h0061 && u <= 16'h007a) return 1'b1;
    if (u >= 16'h0041 && u <= 16'h005a) return 1'b1;
    if (u >= 16'h0030 && u <= 16'h0039) return 1'b1;
    return u == 16'h005f;
  endfunction

  function automatic void brk_push(unit_t u);
    if (brk_fill < BRK_DEPTH) begin
      brk_buf[brk_fill] = u;
      brk_fill++;
    end else begin
      brk_dropped = 1'b1;
    end
  endfunction

  function automatic void brk_close();
    brk_open    = 1'b0;
    brk_fresh   = 1'b0;
    brk_fill    = 0;
    brk_dropped = 1'b0;
  endfunction

  // expected regex text for one accepted code unit
  function automatic void translate_unit(unit_t c, logic last);
    unit_t run [$];
    logic  ovf;
    emit_t w;
    ovf = 1'b0;
    if (brk_open) begin
      if (brk_fresh && c == CH_BANG) begin
        brk_fresh = 1'b0;
        brk_push(CH_CARET);
      end else if (c == CH_RBRK) begin
        ovf = brk_dropped;
        for (int k = 0; k < brk_fill; k++) run.push_back(brk_buf[k]);
        run.push_back(CH_RBRK);
        brk_close();
      end else begin
        brk_fresh = 1'b0;
        if (c == CH_BSL) brk_push(CH_BSL);
        brk_push(c);
      end
    end else begin
      case (c)
        CH_BSL: begin
          if (esc_pend) begin
            run.push_back(CH_BSL);
            run.push_back(CH_BSL);
          end
          if (last) begin
            run.push_back(CH_BSL);
            run.push_back(CH_BSL);
          end
          esc_pend = 1'b1;
        end
        CH_STAR: begin
          run.push_back(esc_pend ? CH_BSL : CH_DOT);
          run.push_back(CH_STAR);
          esc_pend = 1'b0;
        end
        CH_QMARK: begin
          if (esc_pend) begin
            run.push_back(CH_BSL);
            run.push_back(CH_QMARK);
          end else begin
            run.push_back(CH_DOT);
          end
          esc_pend = 1'b0;
        end
        CH_DOLLAR, CH_LPAR, CH_RPAR, CH_PLUS, CH_DOT,
        CH_CARET, CH_LBRACE, CH_BAR, CH_RBRACE: begin
          if (esc_pend) begin
            run.push_back(CH_BSL);
            run.push_back(CH_BSL);
          end
          esc_pend = 1'b0;
          run.push_back(CH_BSL);
          run.push_back(c);
        end
        CH_LBRK: begin
          if (esc_pend) begin
            esc_pend = 1'b0;
            run.push_back(CH_BSL);
            run.push_back(CH_LBRK);
          end else begin
            brk_close();
            brk_open  = 1'b1;
            brk_fresh = 1'b1;
            brk_push(CH_LBRK);
          end
        end
        CH_RBRK: begin
          if (esc_pend) run.push_back(CH_BSL);
          esc_pend = 1'b0;
          run.push_back(CH_RBRK);
        end
        default: begin
          if (esc_pend) begin
            run.push_back(CH_BSL);
            run.push_back(CH_BSL);
          end
          esc_pend = 1'b0;
          run.push_back(c);
        end
      endcase
    end
    // unterminated class is flushed in escaped form
    if (last && brk_open) begin
      ovf = brk_dropped;
      for (int k = 0; k < brk_fill; k++) begin
        if (is_word_unit(brk_buf[k])) begin
          run.push_back(brk_buf[k]);
        end else if (brk_buf[k] == CH_NUL) begin
          run.push_back(CH_BSL);
          run.push_back(CH_ZERO);
        end else begin
          run.push_back(CH_BSL);
          run.push_back(brk_buf[k]);
        end
      end
    end
    if (last) begin
      esc_pend = 1'b0;
      brk_close();
    end
    foreach (run[i]) begin
      w.unit         = run[i];
      w.run_last     = (i == run.size() - 1);
      w.pattern_done = (i == run.size() - 1) && last;
      w.overflow     = ovf;
      regex_q.push_back(w);
    end
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= 100) begin
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  // input monitor feeds the translator, output words are checked in order
  always @(posedge clk) begin
    emit_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) translate_unit(in_code_unit, in_end_of_pattern);
      if (out_valid && !out_stall) begin
        if (regex_q.size() == 0) begin
          flag_mismatch("unexpected word", out_unit, 16'h0000);
        end else begin
          want = regex_q.pop_front();
          if (out_unit !== want.unit) flag_mismatch("unit", out_unit, want.unit);
          if (out_run_last !== want.run_last) begin
            flag_mismatch("run_last", out_run_last, want.run_last);
          end
          if (out_pattern_done !== want.pattern_done) begin
            flag_mismatch("pattern_done", out_pattern_done, want.pattern_done);
          end
          if (out_overflow !== want.overflow) begin
            flag_mismatch("overflow", out_overflow, want.overflow);
          end
        end
      end
    end
  end

  // receiver: random stall, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_word(unit_t u, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_code_unit      <= u;
    in_end_of_pattern <= last;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (regex_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic unit_t pick_unit();
    unit_t meta [9];
    meta = '{CH_DOLLAR, CH_LPAR, CH_RPAR, CH_PLUS, CH_DOT,
             CH_CARET, CH_LBRACE, CH_BAR, CH_RBRACE};
    case ($urandom_range(0, 13))
      0:       return unit_t'($urandom_range(16'h0041, 16'h005a));
      1, 2:    return unit_t'($urandom_range(16'h0061, 16'h007a));
      3:       return unit_t'($urandom_range(16'h0030, 16'h0039));
      4:       return meta[$urandom_range(0, 8)];
      5:       return CH_STAR;
      6:       return CH_QMARK;
      7:       return CH_BSL;
      8:       return CH_LBRK;
      9:       return ($urandom_range(0, 1) != 0) ? CH_RBRK : CH_BANG;
      10:      return unit_t'($urandom_range(0, 65535));
      11:      return ($urandom_range(0, 1) != 0) ? CH_NUL : 16'hffff;
      12:      return 16'h005f;
      default: return unit_t'($urandom_range(0, 127));
    endcase
  endfunction

  // mostly well-formed classes with random content, some left open
  task automatic send_random_pattern();
    unit_t       pat [$];
    int unsigned n;
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0) begin
        pat.push_back(CH_LBRK);
        if ($urandom_range(0, 2) == 0) pat.push_back(CH_BANG);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 5);
        repeat (n) pat.push_back(pick_unit());
        if ($urandom_range(0, 4) != 0) pat.push_back(CH_RBRK);
      end else begin
        pat.push_back(pick_unit());
      end
    end
    foreach (pat[i]) send_word(pat[i], i == pat.size() - 1);
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // wildcards, escapes and metacharacters
    send_word(CH_STAR, 1'b0);
    send_word(CH_QMARK, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_QMARK, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_DOLLAR, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_LBRK, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_RBRK, 1'b0);
    send_word(CH_NUL, 1'b0);
    send_word(16'hffff, 1'b1);
    // negated class with a backslash inside
    send_word(CH_LBRK, 1'b0);
    send_word(CH_BANG, 1'b0);
    send_word(16'h0061, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_RBRK, 1'b0);
    // empty class, then trailing backslash
    send_word(CH_LBRK, 1'b0);
    send_word(CH_RBRK, 1'b0);
    send_word(CH_BSL, 1'b1);
    // open class flushed at end of pattern
    send_word(CH_LBRK, 1'b0);
    send_word(CH_NUL, 1'b0);
    send_word(16'h0078, 1'b0);
    send_word(CH_DOT, 1'b1);
    wait_drained();
  endtask

  task automatic test_bracket_overflow();
    idle_pct  = 0;
    stall_pct = 0;
    // released class longer than the buffer
    send_word(CH_LBRK, 1'b0);
    for (int i = 0; i < 20; i++) send_word(unit_t'(16'h0061 + i), 1'b0);
    send_word(CH_RBRK, 1'b0);
    send_word(16'h007a, 1'b1);
    // doubled backslash keeps only its first copy, then flush
    send_word(CH_LBRK, 1'b0);
    for (int i = 0; i < BRK_DEPTH - 2; i++) send_word(unit_t'(16'h0041 + i), 1'b0);
    send_word(CH_BSL, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_hold();
    int unsigned start;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 400;
    start     = words_sent;
    while (words_sent - start < 40) send_random_pattern();
    wait_drained();
  endtask

  task automatic test_random_mix(int unsigned idle, int unsigned stall, int unsigned count);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    while (words_sent - start < count) send_random_pattern();
    wait_drained();
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_code_unit      = '0;
    in_end_of_pattern = 1'b0;
    out_stall         = 1'b0;
    errors            = 0;
    words_sent        = 0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_req          = 0;
    hold_left         = 0;
    offering          = 1'b0;
    esc_pend          = 1'b0;
    brk_close();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_bracket_overflow();
    test_output_hold();
    test_random_mix(0, 0, 80);
    test_random_mix(88, 0, 80);
    test_random_mix(0, 88, 80);
    test_random_mix(29, 29, 80);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### wildcard_to_regex_translator_unit.f
+incdir+rtl
rtl/wtr_pkg.sv
rtl/wtr_bkt_mem.sv
rtl/wtr_seq.sv
rtl/wildcard_to_regex_translator_unit.sv
dv/wildcard_to_regex_translator_unit_tb.sv
